// ===== hw/rtl/esps_pkg.sv =====
// Package for the truncated exp(x)-1 series block.
// Field widths and default parameter values; no dependencies.
package esps_pkg;

  localparam int unsigned XW         = 5;   // x_value width, signed
  localparam int unsigned NW         = 5;   // term_count width, unsigned
  localparam int unsigned OUT_W      = 45;  // series_sum width, signed
  localparam int unsigned MAX_TERMS  = 20;
  localparam int unsigned FRAC_BITS  = 20;

endpackage

// ===== hw/rtl/esps_div.sv =====
// Bit-serial restoring divider: unsigned dividend by a small unsigned divisor,
// one quotient bit per cycle. Depends on nothing outside this file.
module esps_div #(
  parameter int unsigned DVD_W = 45,
  parameter int unsigned DVS_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;

  logic [DVS_W:0]   trial;
  logic             fits;
  logic [DVS_W:0]   diff;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      // shift the next dividend bit into the remainder, keep it if it fits
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/exp_series_partial_sum.sv =====
// Truncated series of e^x - 1 with a serial divider per term.
// Uses esps_pkg and esps_div.
//
// One transfer in gives one transfer out: series_sum = sum over i = 1..n of
// x^i / i!, fixed point with FRAC_BITS fraction bits, n saturated to
// MAX_TERMS, saturated to the output width. Each term is a multiply by x in
// ST_MUL, then a TERM_W-bit divide by i in the bit-serial divider in ST_DIV,
// TERM_W being FRAC_BITS + 25. One item is worked at a time; the next input
// transfer is taken once the sum has moved into the output register, even if
// it waits there.
module exp_series_partial_sum #(
  parameter int unsigned MAX_TERMS = esps_pkg::MAX_TERMS,
  parameter int unsigned FRAC_BITS = esps_pkg::FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [esps_pkg::XW-1:0] x_value_i,
  input  logic [esps_pkg::NW-1:0]     term_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [esps_pkg::OUT_W-1:0] series_sum_o
);
  import esps_pkg::*;

  // |term * x| stays below 2^(FRAC_BITS+24) for |x| <= 16
  localparam int unsigned TERM_W = FRAC_BITS + 25;
  localparam int unsigned SUM_W  = (FRAC_BITS + 26 > OUT_W) ? FRAC_BITS + 26 : OUT_W;
  localparam int unsigned CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int unsigned PROD_W = TERM_W + XW;

  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                    state_q;
  logic signed [XW-1:0]      x_q;
  logic [CNT_W-1:0]          n_q;
  logic [CNT_W-1:0]          idx_q;
  logic signed [TERM_W-1:0]  term_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic                      neg_q;
  logic                      out_valid_q;
  logic signed [OUT_W-1:0]   out_sum_q;

  logic [5:0]                n_sat;
  logic signed [PROD_W-1:0]  prod;
  logic [TERM_W-1:0]         prod_t;
  logic [TERM_W-1:0]         mag;
  logic                      div_start;
  logic                      div_done;
  logic [TERM_W-1:0]         quo;
  logic signed [TERM_W-1:0]  new_term;
  logic signed [SUM_W-1:0]   new_sum;
  logic                      out_free;
  logic signed [OUT_W-1:0]   sat_sum;

  assign n_sat = ({1'b0, term_count_i} > 6'(MAX_TERMS)) ? 6'(MAX_TERMS)
                                                        : {1'b0, term_count_i};

  assign prod   = term_q * x_q;
  assign prod_t = prod[TERM_W-1:0];
  assign mag    = prod[PROD_W-1] ? (~prod_t + 1'b1) : prod_t;

  assign div_start = (state_q == ST_MUL);

  esps_div #(
    .DVD_W (TERM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (idx_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // truncation toward zero: divide the magnitude, then restore the sign
  assign new_term = neg_q ? $signed(~quo + 1'b1) : $signed(quo);
  assign new_sum  = sum_q + {{(SUM_W - TERM_W){new_term[TERM_W-1]}}, new_term};

  assign sat_sum = (sum_q > SAT_MAX) ? SAT_MAX[OUT_W-1:0] :
                   (sum_q < SAT_MIN) ? SAT_MIN[OUT_W-1:0] : sum_q[OUT_W-1:0];

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            n_q     <= n_sat[CNT_W-1:0];
            idx_q   <= CNT_W'(1);
            state_q <= (n_sat == 6'd0) ? ST_DONE : ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            idx_q   <= idx_q + 1'b1;
            state_q <= (idx_q == n_q) ? ST_DONE : ST_MUL;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      x_q    <= x_value_i;
      term_q <= TERM_W'(1) << FRAC_BITS;
      sum_q  <= '0;
    end
    if (state_q == ST_MUL) begin
      neg_q <= prod[PROD_W-1];
    end
    if (state_q == ST_DIV && div_done) begin
      term_q <= new_term;
      sum_q  <= new_sum;
    end
    if (state_q == ST_DONE && out_free) begin
      out_sum_q <= sat_sum;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign series_sum_o = out_sum_q;

endmodule

// ===== test/exp_series_sum_checker.sv =====
// Checker for exp_series_partial_sum: watches both channels, predicts each sum
// from the accepted x and term count, and compares in order. Uses esps_pkg.
module exp_series_sum_checker
  import esps_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [XW-1:0]    x_value_i,
  input  logic [NW-1:0]           term_count_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [OUT_W-1:0] series_sum_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      sums_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SUM_HI = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint SUM_LO = -SUM_HI - 1;

  logic signed [OUT_W-1:0] sum_queue[$];
  int fails;
  int checked;

  // Build each term from the previous one; the divide truncates toward zero.
  function automatic logic signed [OUT_W-1:0] series_sum_of(
    input logic signed [XW-1:0] x,
    input logic [NW-1:0]        n
  );
    longint      base;
    longint      term;
    longint      acc;
    int unsigned terms;
    int unsigned k;
    base  = longint'(x);
    terms = (n > MAX_TERMS) ? MAX_TERMS : n;
    term  = longint'(1) <<< FRAC_BITS;
    acc   = 0;
    for (k = 1; k <= terms; k++) begin
      term = (term * base) / longint'(k);
      acc  = acc + term;
    end
    if (acc > SUM_HI) acc = SUM_HI;
    if (acc < SUM_LO) acc = SUM_LO;
    return acc[OUT_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [OUT_W-1:0] want;
    if (!rst_ni) begin
      sum_queue.delete();
      fails          = 0;
      checked        = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      sums_checked_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (sum_queue.size() == 0) begin
          $error("series_sum: got %0d with no sum expected", series_sum_i);
          fails++;
        end else begin
          want = sum_queue.pop_front();
          if (series_sum_i !== want) begin
            $error("series_sum mismatch: expected %0d, actual %0d", want, series_sum_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        sum_queue.push_back(series_sum_of(x_value_i, term_count_i));
      // Publish with nonblocking updates so readers at this edge see old values.
      fail_count_o   <= fails;
      pending_o      <= sum_queue.size();
      sums_checked_o <= checked;
    end
  end

endmodule

// ===== test/tb_exp_series_partial_sum.sv =====
// Testbench top for exp_series_partial_sum: clock, reset, directed and random
// transfers with idle and stall gaps, watchdog and verdict. Uses esps_pkg.
module tb_exp_series_partial_sum;
  import esps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 3000;
  localparam int SETTLE_CYCLES  = 1000;
  localparam int DIRECTED_ITEMS = 24;

  logic                    clk_i;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic signed [XW-1:0]    x_value_i    = '0;
  logic [NW-1:0]           term_count_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic signed [OUT_W-1:0] series_sum_o;

  int fail_count;
  int pending;
  int sums_checked;
  int items_sent  = 0;
  int idle_cycles = 0;
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;

  exp_series_partial_sum uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .x_value_i    (x_value_i),
    .term_count_i (term_count_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .series_sum_o (series_sum_o)
  );

  exp_series_sum_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .x_value_i      (x_value_i),
    .term_count_i   (term_count_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .series_sum_i   (series_sum_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .sums_checked_o (sums_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int unsigned pick_gap(input int unsigned long_max);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(20, long_max);
  endfunction

  // Returns at the edge that accepted the transfer.
  task automatic send_item(input logic signed [XW-1:0] x, input logic [NW-1:0] n);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap(400);
    if (gap != 0) begin
      in_valid_i   <= 1'b0;
      x_value_i    <= XW'($urandom());
      term_count_i <= NW'($urandom());
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    x_value_i    <= x;
    term_count_i <= n;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid and hold off until every predicted sum has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Keep most term counts small; the divider makes long series slow.
  task automatic run_random(input int count);
    int                   k;
    int unsigned          r;
    logic signed [XW-1:0] x;
    logic [NW-1:0]        n;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 80) x = XW'(int'($urandom_range(0, 16)) - 8);
      else        x = XW'($urandom());
      r = $urandom_range(0, 99);
      if (r < 65)      n = NW'($urandom_range(0, 6));
      else if (r < 90) n = NW'($urandom_range(7, 20));
      else             n = NW'($urandom_range(21, 31));
      send_item(x, n);
    end
  endtask

  initial begin : receiver
    int unsigned stall_left;
    bit          hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
        stall_left = 0;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = pick_gap(300);
        out_stall_i <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_exp_series_partial_sum: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int k;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero terms, one term, saturated term counts, bases beyond -8..8.
    send_item(0, 0);    send_item(8, 0);    send_item(-16, 0);
    send_item(1, 1);    send_item(-1, 1);   send_item(8, 1);
    send_item(-8, 1);   send_item(8, 20);   send_item(-8, 20);
    send_item(15, 20);  send_item(-16, 20); send_item(-16, 31);
    send_item(15, 31);  send_item(0, 20);   send_item(1, 20);
    send_item(-1, 21);  send_item(7, 25);   send_item(-9, 16);
    send_item(3, 5);    send_item(-3, 5);   send_item(2, 10);
    send_item(-2, 10);  send_item(0, 31);   send_item(12, 19);
    drain();

    // Long output hold while the input side keeps pushing: fill the block.
    quiet    <= 1'b1;
    hold_req <= 1'b1;
    for (k = 0; k < 8; k++) send_item(XW'($urandom()), NW'($urandom_range(0, 6)));
    drain();
    quiet <= 1'b0;

    run_random(260);
    drain();
    quiet <= 1'b1;
    run_random(100);
    quiet <= 1'b0;
    run_random(190);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d transfers (%0d directed, rest random with idle/stall gaps and a %0d-cycle",
             items_sent, DIRECTED_ITEMS, LONG_HOLD);
    $display("output hold); %0d sums checked, %0d mismatches.", sums_checked, fail_count);
    if (fail_count == 0) begin
      $display("tb_exp_series_partial_sum: PASS");
    end else begin
      $display("tb_exp_series_partial_sum: FAIL");
    end
    $finish;
  end

endmodule
